// ===== sv/slrl_pkg.sv =====
// Package for the sliding window log rate limiter: field widths, codes and register indexes.
`default_nettype none

package slrl_pkg;

  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 32;
  localparam int unsigned MAXREQ_W    = 5;
  localparam int unsigned WINDOW_W    = 31;

  localparam int unsigned CLIENT_W    = 8;
  localparam int unsigned NOW_W       = 32;
  localparam int unsigned RETRY_W     = 31;
  localparam int unsigned ACTIVE_W    = 5;

  localparam int unsigned IN_TDATA_W  = 40;
  localparam int unsigned OUT_TDATA_W = 40;

  localparam logic [MAXREQ_W-1:0] MAXREQ_RESET = MAXREQ_W'(10);
  localparam logic [WINDOW_W-1:0] WINDOW_RESET = WINDOW_W'(60);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MAX_REQUESTS = 2'd0,
    REG_WINDOW_TICKS = 2'd1
  } reg_idx_e;

  typedef enum logic {
    KIND_REQUEST = 1'b0,
    KIND_QUERY   = 1'b1
  } kind_e;

endpackage

`default_nettype wire

// ===== sv/sliding_log_rate_limiter.sv =====
// Sliding window log rate limiter: per-client stamp logs in block memory, serial expiry walk.
//
// One item is in work at a time. An accepted item goes through the metadata read, an expiry
// walk of k stamps (0 to LOG_DEPTH) and the decision before the next one is accepted. During
// the walk each stamp of the client's log is fetched through the single read port of the
// stamp memory, one per cycle, oldest first. The result sits in an output register, so the
// next item is accepted while it waits; that next item then holds in its last step until
// the register is free. After reset the block clears the per-client pointer and count
// memory, one client per cycle, before it accepts the first item; configuration writes
// are taken at any time.
`default_nettype none

module sliding_log_rate_limiter #(
  parameter int unsigned CLIENTS   = 256,
  parameter int unsigned LOG_DEPTH = 16,
  parameter int unsigned TIME_BITS = 32
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               cfg_valid_i,
  output logic                                    cfg_ready_o,
  input  wire logic [slrl_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  wire logic [slrl_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  wire logic                               s_axis_tvalid_i,
  output logic                                    s_axis_tready_o,
  // client [7:0], now [39:8]
  input  wire logic [slrl_pkg::IN_TDATA_W-1:0]    s_axis_tdata_i,
  // kind [0]
  input  wire logic                               s_axis_tuser_i,
  output logic                                    m_axis_tvalid_o,
  input  wire logic                               m_axis_tready_i,
  // throttled [0], retry_after [31:1], active_count [36:32], zero [39:37]
  output logic [slrl_pkg::OUT_TDATA_W-1:0]        m_axis_tdata_o
);
  import slrl_pkg::*;

  localparam int unsigned CLI_W = (CLIENTS > 1) ? $clog2(CLIENTS) : 1;
  localparam int unsigned PTR_W = (LOG_DEPTH > 1) ? $clog2(LOG_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(LOG_DEPTH + 1);
  localparam int unsigned SA_W  = (CLIENTS * LOG_DEPTH > 1) ? $clog2(CLIENTS * LOG_DEPTH) : 1;
  localparam int unsigned SW    = PTR_W + 2;
  localparam int unsigned CW    = (TIME_BITS > WINDOW_W) ? TIME_BITS : WINDOW_W;
  localparam int unsigned LW    = (CNT_W > MAXREQ_W) ? CNT_W : MAXREQ_W;

  typedef struct packed {
    logic [PTR_W-1:0] ptr;
    logic [CNT_W-1:0] cnt;
  } meta_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_META,
    ST_CHECK,
    ST_DECIDE
  } state_e;

  function automatic logic [CLI_W-1:0] wrap_client(logic [CLIENT_W-1:0] c);
    logic [24:0] r;
    r = 25'(c);
    for (int i = CLIENT_W - 1; i >= 0; i--) begin
      if (r >= (25'(CLIENTS) << i)) begin
        r = r - (25'(CLIENTS) << i);
      end
    end
    return CLI_W'(r);
  endfunction

  function automatic logic [PTR_W-1:0] slot_add(logic [PTR_W-1:0] p, logic [CNT_W-1:0] k);
    logic [SW-1:0] sum;
    sum = SW'(p) + SW'(k);
    if (sum >= SW'(LOG_DEPTH)) begin
      sum = sum - SW'(LOG_DEPTH);
    end
    return PTR_W'(sum);
  endfunction

  function automatic logic [SA_W-1:0] stamp_addr(logic [CLI_W-1:0] c, logic [PTR_W-1:0] s);
    return SA_W'(c) * SA_W'(LOG_DEPTH) + SA_W'(s);
  endfunction

  state_e                 state_q;
  logic [CLI_W-1:0]       clr_q;
  logic [MAXREQ_W-1:0]    max_q;
  logic [WINDOW_W-1:0]    win_q;
  kind_e                  kind_q;
  logic [CLI_W-1:0]       c_q;
  logic [TIME_BITS-1:0]   now_q;
  logic [PTR_W-1:0]       ptr_q;
  logic [CNT_W-1:0]       cnt_q;
  logic [TIME_BITS-1:0]   age_q;
  logic                   m_valid_q;
  logic [OUT_TDATA_W-1:0] m_data_q;

  meta_t                  meta_mem [CLIENTS];
  meta_t                  meta_rdata_q;
  logic [CLI_W-1:0]       meta_raddr;
  logic                   meta_we;
  logic [CLI_W-1:0]       meta_waddr;
  meta_t                  meta_wdata;

  logic [TIME_BITS-1:0]   st_mem [CLIENTS * LOG_DEPTH];
  logic [TIME_BITS-1:0]   st_rdata_q;
  logic [SA_W-1:0]        st_raddr;
  logic                   st_we;
  logic [SA_W-1:0]        st_waddr;

  logic                   s_xfer;
  logic                   out_free;
  logic [PTR_W-1:0]       ptr_inc;
  logic [TIME_BITS-1:0]   age;
  logic                   expired;
  logic [LW-1:0]          limit;
  logic                   full;
  logic                   append;
  logic [CNT_W-1:0]       cnt_new;
  logic [RETRY_W-1:0]     retry;
  logic [CW-1:0]          diff;

  assign cfg_ready_o     = 1'b1;
  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;

  assign s_xfer   = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free = !m_valid_q || m_axis_tready_i;
  assign ptr_inc  = slot_add(ptr_q, CNT_W'(1));
  assign age      = now_q - st_rdata_q;
  assign expired  = CW'(age) > CW'(win_q);
  assign limit    = (LW'(max_q) > LW'(LOG_DEPTH)) ? LW'(LOG_DEPTH) : LW'(max_q);
  assign full     = LW'(cnt_q) >= limit;
  assign append   = (kind_q == KIND_REQUEST) && !full;
  assign cnt_new  = append ? cnt_q + CNT_W'(1) : cnt_q;
  assign diff     = CW'(win_q) - CW'(age_q);

  always_comb begin
    retry = '0;
    if (kind_q == KIND_QUERY && cnt_q != '0) begin
      if (CW'(age_q) < CW'(win_q)) begin
        retry = RETRY_W'(diff);
      end else begin
        retry = RETRY_W'(1);
      end
    end
  end

  always_comb begin
    meta_raddr = wrap_client(s_axis_tdata_i[CLIENT_W-1:0]);
    st_raddr   = (state_q == ST_META) ? stamp_addr(c_q, meta_rdata_q.ptr)
                                      : stamp_addr(c_q, ptr_inc);
    meta_we    = (state_q == ST_CLEAR) || (state_q == ST_DECIDE && out_free);
    meta_waddr = (state_q == ST_CLEAR) ? clr_q : c_q;
    meta_wdata = (state_q == ST_CLEAR) ? '0 : meta_t'{ptr: ptr_q, cnt: cnt_new};
    st_we      = (state_q == ST_DECIDE) && out_free && append;
    st_waddr   = stamp_addr(c_q, slot_add(ptr_q, cnt_q));
  end

  always_ff @(posedge clk_i) begin
    if (meta_we) begin
      meta_mem[meta_waddr] <= meta_wdata;
    end
    meta_rdata_q <= meta_mem[meta_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (st_we) begin
      st_mem[st_waddr] <= now_q;
    end
    st_rdata_q <= st_mem[st_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q <= MAXREQ_RESET;
      win_q <= WINDOW_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_MAX_REQUESTS: max_q <= cfg_data_i[MAXREQ_W-1:0];
        REG_WINDOW_TICKS: win_q <= cfg_data_i[WINDOW_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      clr_q     <= '0;
      kind_q    <= KIND_REQUEST;
      c_q       <= '0;
      now_q     <= '0;
      ptr_q     <= '0;
      cnt_q     <= '0;
      age_q     <= '0;
      m_valid_q <= 1'b0;
      m_data_q  <= '0;
    end else begin
      if (m_valid_q && m_axis_tready_i && state_q != ST_DECIDE) begin
        m_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_CLEAR: begin
          clr_q <= clr_q + CLI_W'(1);
          if (clr_q == CLI_W'(CLIENTS - 1)) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (s_xfer) begin
            kind_q  <= kind_e'(s_axis_tuser_i);
            c_q     <= meta_raddr;
            now_q   <= TIME_BITS'(s_axis_tdata_i[CLIENT_W +: NOW_W]);
            state_q <= ST_META;
          end
        end
        ST_META: begin
          ptr_q <= meta_rdata_q.ptr;
          cnt_q <= meta_rdata_q.cnt;
          state_q <= (meta_rdata_q.cnt == '0) ? ST_DECIDE : ST_CHECK;
        end
        ST_CHECK: begin
          if (expired) begin
            ptr_q <= ptr_inc;
            cnt_q <= cnt_q - CNT_W'(1);
            if (cnt_q == CNT_W'(1)) begin
              state_q <= ST_DECIDE;
            end
          end else begin
            age_q   <= age;
            state_q <= ST_DECIDE;
          end
        end
        ST_DECIDE: begin
          if (out_free) begin
            m_valid_q <= 1'b1;
            m_data_q  <= OUT_TDATA_W'({ACTIVE_W'(cnt_new), retry,
                                       (kind_q == KIND_REQUEST) && full});
            state_q   <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== sv/slrl_checker.sv =====
// Port-level checker for the sliding window log rate limiter, bound to the top level.
`default_nettype none

module slrl_checker #(
  parameter int unsigned LOG_DEPTH = 16
) (
  input wire logic                               clk_i,
  input wire logic                               rst_ni,
  input wire logic                               cfg_valid_i,
  input wire logic                               cfg_ready_o,
  input wire logic [slrl_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input wire logic [slrl_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input wire logic                               s_axis_tvalid_i,
  input wire logic                               s_axis_tready_o,
  input wire logic [slrl_pkg::IN_TDATA_W-1:0]    s_axis_tdata_i,
  input wire logic                               s_axis_tuser_i,
  input wire logic                               m_axis_tvalid_o,
  input wire logic                               m_axis_tready_i,
  input wire logic [slrl_pkg::OUT_TDATA_W-1:0]   m_axis_tdata_o
);
  import slrl_pkg::*;

  logic s_xfer;
  logic cfg_seen;
  logic unused_ok;

  assign s_xfer    = s_axis_tvalid_i && s_axis_tready_o;
  assign cfg_seen  = cfg_valid_i && cfg_ready_o;
  assign unused_ok = cfg_seen ^ (^cfg_index_i) ^ (^cfg_data_i) ^ (^s_axis_tdata_i)
                     ^ s_axis_tuser_i;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("result changed while stalled");

  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_xfer |=> !s_axis_tready_o)
    else $error("second item accepted while one is in work");

  a_no_instant_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_xfer |=> !$rose(m_axis_tvalid_o))
    else $error("result appeared without a stamp lookup");

  a_result_sane: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (!m_axis_tdata_o[0] || m_axis_tdata_o[RETRY_W:1] == '0)
                        && (32'(m_axis_tdata_o[RETRY_W+ACTIVE_W:RETRY_W+1]) <= LOG_DEPTH)
                        && (m_axis_tdata_o[OUT_TDATA_W-1:RETRY_W+ACTIVE_W+1] == '0))
    else $error("inconsistent result fields");

  a_clear_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) || unused_ok || !unused_ok |-> !(m_axis_tvalid_o && $past(!rst_ni)))
    else $error("result valid right after reset");

endmodule

bind sliding_log_rate_limiter slrl_checker #(.LOG_DEPTH(LOG_DEPTH)) u_slrl_checker (.*);

`default_nettype wire
